### rtl/core/ggnf_pkg.sv
package ggnf_pkg;

  localparam int unsigned MAX_NEIGHBORS_DEF = 32;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  // magnitude of 2W - S - O stays below 2^18
  localparam int unsigned MAG_W = 18;
  localparam int unsigned SQ_W  = 2 * MAG_W;
  localparam int unsigned SUM_W = SQ_W + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_ID = 2'd0,
    CFG_OWN_X  = 2'd1,
    CFG_OWN_Y  = 2'd2,
    CFG_OWN_Z  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OC_ADDED  = 2'd0,
    OC_ACCEPT = 2'd1,
    OC_REJECT = 2'd2,
    OC_FULL   = 2'd3
  } outcome_e;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               valid;
    logic               gabriel;
  } entry_t;

  // one probe into the distance unit
  typedef struct packed {
    logic            act;
    logic            diam;   // squared diameter, else candidate entry
    logic            cand;   // entry may act as witness
    logic [ID_W-1:0] id;
  } probe_t;

  typedef struct packed {
    logic            wit;
    logic [ID_W-1:0] id;
  } res_t;

endpackage

### rtl/core/gabriel_graph_neighbor_filter.sv
// A taken word runs through PREP, SCAN, DRAIN and DONE; commit registers the result word.
// SCAN turns the table ring one full turn past the single shared distance unit. A new word
// is taken only in IDLE, after the last word has committed.
// Output register lets a new word enter while the last result waits.
// Reset: async active low; table emptied through per-slot valid bits, count and
// own_* registers cleared, handshake idle. No clearing pass.
module gabriel_graph_neighbor_filter #(
  parameter int unsigned MAX_NEIGHBORS = ggnf_pkg::MAX_NEIGHBORS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config
  input  logic                            cfg_we_i,
  input  logic [ggnf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ggnf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // hello in
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] sender_id_i,
  input  logic [15:0] sender_x_i,
  input  logic [15:0] sender_y_i,
  input  logic [15:0] sender_z_i,
  // result out
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  outcome_o,
  output logic [4:0]  entry_index_o,
  output logic [15:0] witness_id_o,
  output logic [5:0]  neighbor_count_o
);

  localparam int unsigned IW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int unsigned CW = $clog2(MAX_NEIGHBORS + 1);
  localparam logic [IW-1:0] LAST_SLOT = IW'(MAX_NEIGHBORS - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(MAX_NEIGHBORS);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PREP  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e st_q, st_d;

  // own node registers; own id plays no part in the test
  logic [15:0] own_x_q, own_y_q, own_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_x_q  <= '0;
      own_y_q  <= '0;
      own_z_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ggnf_pkg::CFG_OWN_ID: ;
        ggnf_pkg::CFG_OWN_X:  own_x_q  <= cfg_data_i;
        ggnf_pkg::CFG_OWN_Y:  own_y_q  <= cfg_data_i;
        ggnf_pkg::CFG_OWN_Z:  own_z_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // latched hello word
  logic        in_take;
  ggnf_pkg::entry_t snd_q;

  assign in_stall_o = (st_q != ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      snd_q.id      <= sender_id_i;
      snd_q.x       <= sender_x_i;
      snd_q.y       <= sender_y_i;
      snd_q.z       <= sender_z_i;
      snd_q.valid   <= 1'b1;
      snd_q.gabriel <= 1'b0;
    end
  end

  // table ring: slot k sits in cell k when the ring is at rest;
  // a scan rotates it one full turn past cell 0
  ggnf_pkg::entry_t cells [MAX_NEIGHBORS];
  ggnf_pkg::entry_t head;
  logic             shift;
  logic             add_en, gab_en;
  logic [CW-1:0]    used_q;
  logic [IW-1:0]    slot_q;

  assign shift = (st_q == ST_SCAN);
  assign head  = cells[0];

  for (genvar k = 0; k < MAX_NEIGHBORS; k++) begin : g_cell
    ggnf_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shift_i   (shift),
      .nb_i      (cells[(k + 1) % MAX_NEIGHBORS]),
      .wr_i      (add_en && (used_q[IW-1:0] == IW'(k))),
      .wr_data_i (snd_q),
      .set_gab_i (gab_en && (slot_q == IW'(k))),
      .q_o       (cells[k])
    );
  end

  // scan position = slot currently in cell 0
  logic [IW-1:0] scan_q;
  logic          found_q;
  logic          head_match;

  assign head_match = head.valid && (head.id == snd_q.id) && (head.x == snd_q.x) &&
                      (head.y == snd_q.y) && (head.z == snd_q.z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= '0;
      found_q <= 1'b0;
    end else if (in_take) begin
      scan_q  <= '0;
      found_q <= 1'b0;
    end else if (shift) begin
      scan_q <= (scan_q == LAST_SLOT) ? '0 : scan_q + 1'b1;
      if (head_match && !found_q) found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift && head_match && !found_q) slot_q <= scan_q;
  end

  // distance unit: diameter in PREP, one candidate per scan cycle
  ggnf_pkg::probe_t probe;
  ggnf_pkg::res_t   res;

  assign probe.act  = (st_q == ST_PREP) || shift;
  assign probe.diam = (st_q == ST_PREP);
  assign probe.cand = head.valid && (head.id != snd_q.id);
  assign probe.id   = head.id;

  ggnf_gabriel_unit u_gab (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .probe_i (probe),
    .w_x_i   (head.x),
    .w_y_i   (head.y),
    .w_z_i   (head.z),
    .s_x_i   (snd_q.x),
    .s_y_i   (snd_q.y),
    .s_z_i   (snd_q.z),
    .o_x_i   (own_x_q),
    .o_y_i   (own_y_q),
    .o_z_i   (own_z_q),
    .res_o   (res)
  );

  // first witness in slot order
  logic        wit_q;
  logic [15:0] wit_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wit_q <= 1'b0;
    end else if (in_take) begin
      wit_q <= 1'b0;
    end else if (res.wit && !wit_q) begin
      wit_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.wit && !wit_q) wit_id_q <= res.id;
  end

  // commit and result
  logic             commit, out_valid_q, full;
  ggnf_pkg::outcome_e oc_d, oc_q;
  logic [4:0]       idx_d, idx_q;
  logic [15:0]      wid_d, wid_q;
  logic [CW-1:0]    used_d;
  logic [5:0]       cnt_q;

  assign commit = (st_q == ST_DONE) && !(out_valid_q && out_stall_i);
  assign full   = (used_q >= FULL_CNT);
  assign add_en = commit && !found_q && !full;
  assign gab_en = commit && found_q && !wit_q;
  assign used_d = add_en ? used_q + 1'b1 : used_q;

  always_comb begin
    oc_d  = ggnf_pkg::OC_ACCEPT;
    idx_d = 5'(slot_q);
    wid_d = '0;
    if (!found_q) begin
      if (full) begin
        oc_d  = ggnf_pkg::OC_FULL;
        idx_d = '0;
      end else begin
        oc_d  = ggnf_pkg::OC_ADDED;
        idx_d = 5'(used_q[IW-1:0]);
      end
    end else if (wit_q) begin
      oc_d  = ggnf_pkg::OC_REJECT;
      wid_d = wit_id_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      used_q <= used_d;
      if (commit)            out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      oc_q  <= oc_d;
      idx_q <= idx_d;
      wid_q <= wid_d;
      cnt_q <= 6'(used_d);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign outcome_o        = oc_q;
  assign entry_index_o    = idx_q;
  assign witness_id_o     = wid_q;
  assign neighbor_count_o = cnt_q;

  // sequencer
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:  if (in_take) st_d = ST_PREP;
      ST_PREP:  st_d = ST_SCAN;
      ST_SCAN:  if (scan_q == LAST_SLOT) st_d = ST_DRAIN;
      ST_DRAIN: st_d = ST_DONE;
      ST_DONE:  if (commit) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= ST_IDLE;
    else         st_q <= st_d;
  end

  // checks
  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_o)
    else $error("commit did not raise out_valid");

  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !add_en |=> used_q == $past(used_q))
    else $error("neighbor count moved without an add");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_en |=> used_q <= FULL_CNT)
    else $error("neighbor count exceeds table size");

  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SCAN && scan_q == LAST_SLOT) |=> (st_q == ST_DRAIN && scan_q == '0))
    else $error("ring not back at rest after scan");

  a_one_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(add_en && gab_en))
    else $error("add and accept in one commit");

endmodule

### rtl/core/ggnf_cell.sv
module ggnf_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  ggnf_pkg::entry_t  nb_i,
  input  logic              wr_i,
  input  ggnf_pkg::entry_t  wr_data_i,
  input  logic              set_gab_i,
  output ggnf_pkg::entry_t  q_o
);

  logic                         valid_q, gab_q;
  logic [ggnf_pkg::ID_W-1:0]    id_q;
  logic [ggnf_pkg::COORD_W-1:0] x_q, y_q, z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      gab_q   <= 1'b0;
    end else if (shift_i) begin
      valid_q <= nb_i.valid;
      gab_q   <= nb_i.gabriel;
    end else if (wr_i) begin
      valid_q <= 1'b1;
      gab_q   <= 1'b0;
    end else if (set_gab_i) begin
      gab_q   <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      id_q <= nb_i.id;
      x_q  <= nb_i.x;
      y_q  <= nb_i.y;
      z_q  <= nb_i.z;
    end else if (wr_i) begin
      id_q <= wr_data_i.id;
      x_q  <= wr_data_i.x;
      y_q  <= wr_data_i.y;
      z_q  <= wr_data_i.z;
    end
  end

  assign q_o = '{id: id_q, x: x_q, y: y_q, z: z_q, valid: valid_q, gabriel: gab_q};

endmodule

### rtl/core/ggnf_gabriel_unit.sv
module ggnf_gabriel_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ggnf_pkg::probe_t             probe_i,
  input  logic [ggnf_pkg::COORD_W-1:0] w_x_i,
  input  logic [ggnf_pkg::COORD_W-1:0] w_y_i,
  input  logic [ggnf_pkg::COORD_W-1:0] w_z_i,
  input  logic [ggnf_pkg::COORD_W-1:0] s_x_i,
  input  logic [ggnf_pkg::COORD_W-1:0] s_y_i,
  input  logic [ggnf_pkg::COORD_W-1:0] s_z_i,
  input  logic [ggnf_pkg::COORD_W-1:0] o_x_i,
  input  logic [ggnf_pkg::COORD_W-1:0] o_y_i,
  input  logic [ggnf_pkg::COORD_W-1:0] o_z_i,
  output ggnf_pkg::res_t               res_o
);

  localparam int unsigned DW = ggnf_pkg::MAG_W + 1;

  logic [ggnf_pkg::COORD_W-1:0] w_c [3];
  logic [ggnf_pkg::COORD_W-1:0] s_c [3];
  logic [ggnf_pkg::COORD_W-1:0] o_c [3];
  logic [ggnf_pkg::SQ_W-1:0]    sq_d [3];
  logic [ggnf_pkg::SQ_W-1:0]    sq_q [3];
  ggnf_pkg::probe_t             tag_q;
  logic [ggnf_pkg::SUM_W-1:0]   diam_q;
  logic [ggnf_pkg::SUM_W-1:0]   sum;

  assign w_c = '{w_x_i, w_y_i, w_z_i};
  assign s_c = '{s_x_i, s_y_i, s_z_i};
  assign o_c = '{o_x_i, o_y_i, o_z_i};

  // diameter: S - O; candidate: 2W - S - O
  always_comb begin
    logic signed [DW-1:0] a, b, d;
    logic [ggnf_pkg::MAG_W-1:0] mag;
    for (int k = 0; k < 3; k++) begin
      if (probe_i.diam) begin
        a = $signed({3'b000, s_c[k]});
        b = $signed({3'b000, o_c[k]});
      end else begin
        a = $signed({2'b00, w_c[k], 1'b0});
        b = $signed({3'b000, s_c[k]}) + $signed({3'b000, o_c[k]});
      end
      d = a - b;
      mag = d[DW-1] ? ggnf_pkg::MAG_W'(-d) : d[ggnf_pkg::MAG_W-1:0];
      sq_d[k] = mag * mag;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) sq_q[k] <= sq_d[k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tag_q <= '0;
    else         tag_q <= probe_i;
  end

  assign sum = ggnf_pkg::SUM_W'(sq_q[0]) + ggnf_pkg::SUM_W'(sq_q[1]) +
               ggnf_pkg::SUM_W'(sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (tag_q.act && tag_q.diam) diam_q <= sum;
  end

  assign res_o.wit = tag_q.act && !tag_q.diam && tag_q.cand && (sum <= diam_q);
  assign res_o.id  = tag_q.id;

endmodule
